// ----- rtl/countdown_timer_table_core_defines.svh -----
// Assertion macros for the countdown timer table.
// Simulation gets the checks; synthesis sees empty macros.
`ifndef COUNTDOWN_TIMER_TABLE_CORE_DEFINES_SVH
`define COUNTDOWN_TIMER_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define CTT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("countdown timer table: check failed");

`define CTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("countdown timer table: check failed");

`else

`define CTT_ASSERT(lbl, clk, rstn, prop)

`define CTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/ctt_pkg.sv -----
package ctt_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_FIRED     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_PASS   = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

  // per-cycle control shared by every cell of the chain
  typedef struct packed {
    logic shift;  // take the neighbour's entry
    logic wr_en;  // write the entry on the write bus at wr_idx
  } cell_ctrl_t;

  localparam int unsigned IdBits = 16;

endpackage

// ----- rtl/ctt_cell.sv -----
module ctt_cell #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned IDX_BITS   = 4,
  parameter int unsigned SLOT       = 0
) (
  input  logic                      clk_i,
  input  ctt_pkg::cell_ctrl_t       ctrl_i,
  input  logic [IDX_BITS-1:0]       wr_idx_i,
  input  logic [ctt_pkg::IdBits-1:0] wr_id_i,
  input  logic [COUNT_BITS-1:0]     wr_rem_i,
  input  logic [ctt_pkg::IdBits-1:0] nb_id_i,
  input  logic [COUNT_BITS-1:0]     nb_rem_i,
  output logic [ctt_pkg::IdBits-1:0] id_o,
  output logic [COUNT_BITS-1:0]     rem_o
);
  import ctt_pkg::*;

  logic [IdBits-1:0]     id_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic                  sel_wr;

  assign sel_wr = ctrl_i.wr_en && (wr_idx_i == IDX_BITS'(SLOT));

  // write bus wins over the shift from the neighbour
  always_ff @(posedge clk_i) begin
    if (sel_wr) begin
      id_q  <= wr_id_i;
      rem_q <= wr_rem_i;
    end else if (ctrl_i.shift) begin
      id_q  <= nb_id_i;
      rem_q <= nb_rem_i;
    end
  end

  assign id_o  = id_q;
  assign rem_o = rem_q;

endmodule

// ----- rtl/countdown_timer_table_core.sv -----
// Answers: an add answers in the cycle after its transfer; cancel and tick give
//   their final result once the pass over the live entries ends, plus output stalls.
// Throughput: one request at a time; an add every cycle while the output does not
//   stall, a cancel or tick once its pass ends; the pass visits one live slot per cycle unless held by the output.
// Reset (async, active low): table empty, next id 1, output register empty.
//   Cell contents are not reset; only slots below the live count are used.
`include "countdown_timer_table_core_defines.svh"

module countdown_timer_table_core #(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [15:0]               duration_i,
  input  logic [15:0]               timer_id_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                result_kind_o,
  output logic [15:0]               result_id_o,
  output logic                      last_o
);
  import ctt_pkg::*;

  localparam int unsigned IW = $clog2(TIMER_SLOTS);      // slot index
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);  // live count
  localparam int unsigned DW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [DW-1:0] CountMax = DW'({COUNT_BITS{1'b1}});

  // ---------------------------------------------------------------------
  // Cell chain. Live entries are packed at slots 0..cnt-1 in insertion
  // order. A pass pops slot 0 every cycle that it is not held, while all cells
  // shift down by one; a surviving entry is written back behind the entries not yet
  // visited, so after cnt steps the survivors are packed again, in order.
  // ---------------------------------------------------------------------
  cell_ctrl_t            cell_ctrl;
  logic [IW-1:0]         wr_idx;
  logic [IdBits-1:0]     wr_id;
  logic [COUNT_BITS-1:0] wr_rem;
  logic [IdBits-1:0]     cell_id  [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] cell_rem [TIMER_SLOTS];

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    localparam int unsigned Nb = (g == TIMER_SLOTS - 1) ? 0 : g + 1;
    ctt_cell #(
      .COUNT_BITS (COUNT_BITS),
      .IDX_BITS   (IW),
      .SLOT       (g)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .wr_idx_i (wr_idx),
      .wr_id_i  (wr_id),
      .wr_rem_i (wr_rem),
      .nb_id_i  (cell_id[Nb]),
      .nb_rem_i (cell_rem[Nb]),
      .id_o     (cell_id[g]),
      .rem_o    (cell_rem[g])
    );
  end

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;      // live entries
  logic [CW-1:0]     step_q, step_d;    // entries visited in this pass
  logic [CW-1:0]     k_q, k_d;          // survivors written back so far
  logic              tick_q, tick_d;    // pass is a tick, else a cancel
  logic              found_q, found_d;  // cancel already removed its match
  logic [IdBits-1:0] tgt_q, tgt_d;      // id sought by cancel
  logic              pend_q, pend_d;    // a fired id is held back...
  logic [IdBits-1:0] pend_id_q, pend_id_d; // ...until we know if it is last
  logic [IdBits-1:0] next_id_q, next_id_d;

  // output register
  logic              out_valid_q;
  kind_e             out_kind_q, out_kind_d;
  logic [IdBits-1:0] out_id_q, out_id_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;

  logic              in_xfer;
  logic [IdBits-1:0] head_id;
  logic [COUNT_BITS-1:0] head_rem;
  logic              fire;
  logic              hit;
  logic              keep;
  logic              adv;
  logic [CW-1:0]     wp_full;
  logic [DW-1:0]     dur_w;
  logic [COUNT_BITS-1:0] dur_sat;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // long durations saturate to the counter width
  assign dur_w   = DW'(duration_i);
  assign dur_sat = (dur_w > CountMax) ? COUNT_BITS'(CountMax) : COUNT_BITS'(dur_w);

  assign head_id  = cell_id[0];
  assign head_rem = cell_rem[0];
  assign fire     = tick_q && (head_rem <= COUNT_BITS'(1));
  assign hit      = !tick_q && !found_q && (head_id == tgt_q);
  assign keep     = !(fire || hit);
  // a second firing pushes the held one out, which needs the output free
  assign adv      = !(fire && pend_q) || out_free;
  // slot for the survivor: behind the unvisited entries and earlier survivors
  assign wp_full  = cnt_q - step_q - CW'(1) + k_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    k_d        = k_q;
    tick_d     = tick_q;
    found_d    = found_q;
    tgt_d      = tgt_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    next_id_d  = next_id_q;
    out_load   = 1'b0;
    out_kind_d = KIND_ADDED;
    out_id_d   = '0;
    out_last_d = 1'b1;
    cell_ctrl  = '0;
    wr_idx     = cnt_q[IW-1:0];
    wr_id      = next_id_q;
    wr_rem     = dur_sat;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (req_type_i)
            REQ_ADD: begin
              out_load = 1'b1;
              if (cnt_q == CW'(TIMER_SLOTS)) begin
                out_kind_d = KIND_FULL;
              end else begin
                out_kind_d      = KIND_ADDED;
                out_id_d        = next_id_q;
                cell_ctrl.wr_en = 1'b1;
                cnt_d           = cnt_q + CW'(1);
                next_id_d       = next_id_q + IdBits'(1);
              end
            end
            REQ_CANCEL, REQ_TICK: begin
              tick_d  = (req_type_i == REQ_TICK);
              tgt_d   = timer_id_i;
              found_d = 1'b0;
              pend_d  = 1'b0;
              step_d  = '0;
              k_d     = '0;
              state_d = (cnt_q == '0) ? ST_FINISH : ST_PASS;
            end
            default: ;  // unknown request: no effect
          endcase
        end
      end

      ST_PASS: begin
        if (adv) begin
          cell_ctrl.shift = 1'b1;
          cell_ctrl.wr_en = keep;
          wr_idx          = wp_full[IW-1:0];
          wr_id           = head_id;
          wr_rem          = tick_q ? (head_rem - COUNT_BITS'(1)) : head_rem;
          k_d             = k_q + CW'(keep);
          step_d          = step_q + CW'(1);
          if (hit) begin
            found_d = 1'b1;
          end
          if (fire) begin
            pend_d    = 1'b1;
            pend_id_d = head_id;
            if (pend_q) begin
              out_load   = 1'b1;
              out_kind_d = KIND_FIRED;
              out_id_d   = pend_id_q;
              out_last_d = 1'b0;
            end
          end
          if (step_q == cnt_q - CW'(1)) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (tick_q) begin
          if (!pend_q) begin
            cnt_d   = k_q;
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_load   = 1'b1;
            out_kind_d = KIND_FIRED;
            out_id_d   = pend_id_q;
            pend_d     = 1'b0;
            cnt_d      = k_q;
            state_d    = ST_IDLE;
          end
        end else if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = found_q ? KIND_CANCELLED : KIND_NOT_FOUND;
          out_id_d   = found_q ? tgt_q : '0;
          cnt_d      = k_q;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      k_q         <= '0;
      tick_q      <= 1'b0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      next_id_q   <= IdBits'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      step_q    <= step_d;
      k_q       <= k_d;
      tick_q    <= tick_d;
      found_q   <= found_d;
      pend_q    <= pend_d;
      next_id_q <= next_id_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tgt_q     <= tgt_d;
    pend_id_q <= pend_id_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign result_id_o   = out_id_q;
  assign last_o        = out_last_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `CTT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(TIMER_SLOTS))
  `CTT_ASSERT(a_no_overwrite, clk_i, rst_ni, out_load |-> !(out_valid_q && out_stall_i))
  `CTT_ASSERT(a_step_bound, clk_i, rst_ni, (state_q == ST_PASS) |-> (step_q < cnt_q))
  `CTT_ASSERT(a_kept_bound, clk_i, rst_ni, (state_q == ST_PASS) |-> (k_q <= step_q))
  `CTT_ASSERT_NEXT(a_cnt_settle, clk_i, rst_ni, (state_q == ST_FINISH) && (state_d == ST_IDLE), cnt_q == $past(k_q))

endmodule

// ----- tb/sv/countdown_timer_table_core_tb.sv -----
`timescale 1ns / 1ps

module countdown_timer_table_core_tb;
  import ctt_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int CLK_PERIOD = 10;
  localparam int MAX_GAP = 14;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 2 * SLOTS + 8;
  localparam int RANDOM_ITEMS = 75;
  localparam int MAX_PRINTS = 50;
  localparam longint TIMEOUT_NS = 2_000_000;
  // req_type 3 is not decoded by the block: no effect, no answer
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef struct {
    kind_e       kind;
    logic [15:0] id;
    logic        last;
  } timer_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = REQ_ADD;
  logic [15:0] duration_i = 16'd0;
  logic [15:0] timer_id_i = 16'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [15:0] result_id_o;
  logic        last_o;

  // shadow of the timer table, packed at the low slots in insertion order
  logic [15:0]   tbl_id   [SLOTS];
  logic [15:0]   tbl_left [SLOTS];
  int            tbl_count = 0;
  logic [15:0]   tbl_next_id = 16'd1;
  timer_result_t expected_results[$];

  int   err_count = 0;
  bit   idle_on = 1'b1;
  logic long_hold = 1'b0;
  int   rx_wait = 0;
  event long_hold_ev;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  countdown_timer_table_core #(
    .TIMER_SLOTS(SLOTS),
    .COUNT_BITS (16)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .duration_i   (duration_i),
    .timer_id_i   (timer_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .result_id_o  (result_id_o),
    .last_o       (last_o)
  );

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    // cap the log; every mismatch is still counted
    if (err_count < MAX_PRINTS)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic void push_result(kind_e kind, logic [15:0] id, logic fin);
    timer_result_t r;
    r.kind = kind;
    r.id   = id;
    r.last = fin;
    expected_results = {expected_results, r};
  endfunction

  // Table behaviour per accepted request. Durations are 16 bits and the count
  // is 16 bits wide, so the saturation of long durations never bites here.
  function automatic void predict_timer_table(logic [1:0] rt, logic [15:0] dur,
                                              logic [15:0] tid);
    int hit;
    int w;
    int fired;
    case (rt)
      REQ_ADD: begin
        if (tbl_count >= SLOTS) begin
          push_result(KIND_FULL, 16'd0, 1'b1);
        end else begin
          tbl_id[tbl_count]   = tbl_next_id;
          tbl_left[tbl_count] = dur;
          tbl_count++;
          push_result(KIND_ADDED, tbl_next_id, 1'b1);
          tbl_next_id++;  // wraps 65535 -> 0
        end
      end
      REQ_CANCEL: begin
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && tbl_id[i] == tid) hit = i;
        if (hit < 0) begin
          push_result(KIND_NOT_FOUND, 16'd0, 1'b1);
        end else begin
          for (int j = hit; j < tbl_count - 1; j++) begin
            tbl_id[j]   = tbl_id[j + 1];
            tbl_left[j] = tbl_left[j + 1];
          end
          tbl_count--;
          push_result(KIND_CANCELLED, tid, 1'b1);
        end
      end
      REQ_TICK: begin
        w = 0;
        fired = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_left[i] <= 16'd1) begin
            push_result(KIND_FIRED, tbl_id[i], 1'b0);
            fired++;
          end else begin
            tbl_id[w]   = tbl_id[i];
            tbl_left[w] = tbl_left[i] - 16'd1;
            w++;
          end
        end
        tbl_count = w;
        if (fired > 0)
          expected_results[expected_results.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // One request transfer. Valid is left high afterwards so that a back-to-back
  // request needs no second assignment in the same step.
  task automatic send_req(input logic [1:0] rt, input logic [15:0] dur,
                          input logic [15:0] tid);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) != 0) ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      req_type_i <= 2'($urandom_range(0, 3));
      duration_i <= 16'($urandom);
      timer_id_i <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    duration_i <= dur;
    timer_id_i <= tid;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    predict_timer_table(rt, dur, tid);
  endtask

  // sender pauses until every expected result has been seen
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_results.size() != 0);
  endtask

  // quiet tick, cancel misses and a hit, reserved request, add extremes, a double fire
  task automatic test_basic_requests();
    idle_on = 1'b1;
    send_req(REQ_TICK, 16'hFFFF, 16'hFFFF);
    send_req(REQ_CANCEL, 16'hFFFF, 16'd0);
    send_req(REQ_RESERVED, 16'hFFFF, 16'hFFFF);
    send_req(REQ_ADD, 16'd0, 16'hFFFF);
    send_req(REQ_ADD, 16'd1, 16'd0);
    send_req(REQ_ADD, 16'hFFFF, 16'd0);
    send_req(REQ_TICK, 16'd0, 16'd0);
    send_req(REQ_CANCEL, 16'd0, 16'd3);
    send_req(REQ_CANCEL, 16'hFFFF, 16'd3);
    wait_results_done();
  endtask

  // Fill the table behind a long receiver hold so the block backs up, overflow
  // it once, then fire all sixteen entries on a single tick.
  task automatic test_table_full();
    idle_on = 1'b0;
    -> long_hold_ev;
    for (int i = 0; i < SLOTS; i++)
      send_req(REQ_ADD, 16'(i % 2), 16'($urandom));
    send_req(REQ_ADD, 16'd7, 16'($urandom));
    idle_on = 1'b1;
    send_req(REQ_TICK, 16'($urandom), 16'($urandom));
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    int sent;
    int pick;
    logic [15:0] dur;
    logic [15:0] tid;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      tid  = 16'($urandom);
      if (pick < 42) begin
        case ($urandom_range(0, 9))
          0:       dur = 16'd0;
          1:       dur = 16'hFFFF;
          2, 3:    dur = 16'($urandom);
          default: dur = 16'($urandom_range(0, 6));
        endcase
        send_req(REQ_ADD, dur, tid);
        sent++;
      end else if (pick < 65) begin
        // mostly live ids, sometimes a likely miss
        if (tbl_count > 0 && $urandom_range(0, 3) != 0)
          tid = tbl_id[$urandom_range(0, tbl_count - 1)];
        send_req(REQ_CANCEL, 16'($urandom), tid);
        sent++;
      end else if (pick < 95) begin
        send_req(REQ_TICK, 16'($urandom), tid);
        sent++;
      end else begin
        send_req(REQ_RESERVED, 16'($urandom), tid);
      end
      if ($urandom_range(0, 19) == 0) wait_results_done();
    end
    wait_results_done();
  endtask

  // compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin : result_check
    timer_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, id", result_id_o, 16'd0);
      end else begin
        want = expected_results.pop_front();
        if (result_kind_o !== want.kind)
          report_mismatch("result_kind", 16'(result_kind_o), 16'(want.kind));
        if (result_id_o !== want.id)
          report_mismatch("result_id", result_id_o, want.id);
        if (last_o !== want.last)
          report_mismatch("last", 16'(last_o), 16'(want.last));
      end
    end
  end

  // receiver: random hold-off after each transfer, odd stalls while idle,
  // and the long hold when asked for
  always @(posedge clk_i) begin : result_accept
    int w;
    if (long_hold) begin
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else if (out_valid_o === 1'b1 && out_stall_i === 1'b0 && idle_on) begin
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      if (w > 0) begin
        rx_wait = w - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end else begin
      out_stall_i <= idle_on && ($urandom_range(0, 7) == 0);
    end
  end

  initial begin
    forever begin
      @(long_hold_ev);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      long_hold <= 1'b0;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_requests();
    test_table_full();
    test_random_traffic();
    wait_results_done();
    // let a late stray result show up before closing
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ctt_pkg.sv
rtl/ctt_cell.sv
rtl/countdown_timer_table_core.sv
tb/sv/countdown_timer_table_core_tb.sv
